>>> sv/b64u_pkg.sv
package b64u_pkg;

  localparam int unsigned ALPHA_UPPER_END = 26;
  localparam int unsigned ALPHA_LOWER_END = 52;
  localparam int unsigned ALPHA_DIGIT_END = 62;
  localparam logic [5:0] IDX_DASH       = 6'd62;
  localparam logic [5:0] IDX_UNDERSCORE = 6'd63;
  localparam logic [5:0] SEXTET_MASK    = 6'h3F;

  localparam logic [0:0] DIR_ENCODE = 1'b0;
  localparam logic [0:0] DIR_DECODE = 1'b1;

  // One unit of work for the back end: a group of up to 24 bits and the
  // number of results (minus one) that it yields.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  cnt_m1;
    logic        enc;
    logic        err;
    logic        last;
  } job_t;

  // Six-bit index to alphabet character.
  function automatic logic [7:0] idx_to_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'(ALPHA_UPPER_END)) begin
      c = 8'("A") + {2'b00, idx};
    end else if (idx < 6'(ALPHA_LOWER_END)) begin
      c = 8'("a") + {2'b00, idx} - 8'(ALPHA_UPPER_END);
    end else if (idx < 6'(ALPHA_DIGIT_END)) begin
      c = 8'("0") + {2'b00, idx} - 8'(ALPHA_LOWER_END);
    end else if (idx == IDX_DASH) begin
      c = 8'("-");
    end else begin
      c = 8'("_");
    end
    return c;
  endfunction

  // Character to {valid, six-bit value}.
  function automatic logic [6:0] char_to_idx(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'("A") && c <= 8'("Z")) begin
      r = {1'b1, 6'(c - 8'("A"))};
    end else if (c >= 8'("a") && c <= 8'("z")) begin
      r = {1'b1, 6'(c - 8'("a") + 8'(ALPHA_UPPER_END))};
    end else if (c >= 8'("0") && c <= 8'("9")) begin
      r = {1'b1, 6'(c - 8'("0") + 8'(ALPHA_LOWER_END))};
    end else if (c == 8'("-")) begin
      r = {1'b1, IDX_DASH};
    end else if (c == 8'("_")) begin
      r = {1'b1, IDX_UNDERSCORE};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

>>> sv/b64u_front.sv
module b64u_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_dir,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           direction,
  output logic           job_valid,
  output b64u_pkg::job_t job
);
  import b64u_pkg::*;

  logic        direction_r;
  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        err_seen_r, err_seen_nxt;

  logic [23:0] merged;
  logic [6:0]  cv;
  logic [2:0]  p1;

  assign direction = direction_r;

  always_comb begin
    bits_nxt     = bits_r;
    phase_nxt    = phase_r;
    err_seen_nxt = err_seen_r;
    job_valid    = 1'b0;
    job          = '0;
    merged       = bits_r;
    cv           = char_to_idx(in_byte);
    p1           = {1'b0, phase_r} + 3'd1;

    if (direction_r == DIR_ENCODE) begin
      case (phase_r)
        2'd0:    merged = bits_r | {in_byte, 16'd0};
        2'd1:    merged = bits_r | {8'd0, in_byte, 8'd0};
        default: merged = bits_r | {16'd0, in_byte};
      endcase
      // A phase of three cannot occur in encode mode; treat it as two.
      if (phase_r == 2'd3) begin
        p1 = 3'd3;
      end
      job.bits = merged;
      job.enc  = 1'b1;
      job.last = in_last;
      if (p1 == 3'd3) begin
        job_valid = 1'b1;
        job.cnt_m1 = 2'd3;
      end else if (in_last) begin
        job_valid  = 1'b1;
        job.cnt_m1 = p1[1:0];
      end
      if (job_valid) begin
        bits_nxt  = '0;
        phase_nxt = '0;
      end else begin
        bits_nxt  = merged;
        phase_nxt = p1[1:0];
      end
    end else begin
      case (phase_r)
        2'd0:    merged = bits_r | {cv[5:0], 18'd0};
        2'd1:    merged = bits_r | {6'd0, cv[5:0], 12'd0};
        2'd2:    merged = bits_r | {12'd0, cv[5:0], 6'd0};
        default: merged = bits_r | {18'd0, cv[5:0]};
      endcase
      job.bits = merged;
      job.last = in_last;
      if (err_seen_r) begin
        // The rest of a failed message is dropped up to its last item.
        if (in_last) begin
          err_seen_nxt = 1'b0;
          bits_nxt     = '0;
          phase_nxt    = '0;
        end
      end else if (!cv[6]) begin
        job_valid    = 1'b1;
        job.bits     = '0;
        job.err      = 1'b1;
        bits_nxt     = '0;
        phase_nxt    = '0;
        err_seen_nxt = !in_last;
      end else if (p1 == 3'd4) begin
        job_valid  = 1'b1;
        job.cnt_m1 = 2'd2;
        bits_nxt   = '0;
        phase_nxt  = '0;
      end else if (!in_last) begin
        bits_nxt  = merged;
        phase_nxt = p1[1:0];
      end else if (p1 == 3'd1) begin
        // A lone tail character cannot form a byte.
        job_valid = 1'b1;
        job.bits  = '0;
        job.err   = 1'b1;
        bits_nxt  = '0;
        phase_nxt = '0;
      end else begin
        job_valid  = 1'b1;
        job.cnt_m1 = 2'(p1 - 3'd2);
        bits_nxt   = '0;
        phase_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      bits_r      <= '0;
      phase_r     <= '0;
      err_seen_r  <= 1'b0;
    end else if (cfg_we) begin
      direction_r <= cfg_dir;
      bits_r      <= '0;
      phase_r     <= '0;
      err_seen_r  <= 1'b0;
    end else if (accept) begin
      bits_r      <= bits_nxt;
      phase_r     <= phase_nxt;
      err_seen_r  <= err_seen_nxt;
    end
  end

endmodule

>>> sv/b64u_fifo.sv
module b64u_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64u_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output b64u_pkg::job_t rd_job
);
  import b64u_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign rd_job = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> sv/b64u_back.sv
module b64u_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  b64u_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_byte,
  output logic           out_error,
  output logic           out_last
);
  import b64u_pkg::*;

  job_t       job_r;
  logic       job_valid_r, job_valid_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_error_r, out_last_r;

  logic       fire, done;
  logic [5:0] sextet;
  logic [7:0] octet, item_byte;

  assign done = (k_r == job_r.cnt_m1);
  assign fire = job_valid_r && (!out_valid_r || out_pop);

  always_comb begin
    case (k_r)
      2'd0:    sextet = job_r.bits[23:18];
      2'd1:    sextet = job_r.bits[17:12];
      2'd2:    sextet = job_r.bits[11:6];
      default: sextet = job_r.bits[5:0] & SEXTET_MASK;
    endcase
    case (k_r)
      2'd0:    octet = job_r.bits[23:16];
      2'd1:    octet = job_r.bits[15:8];
      default: octet = job_r.bits[7:0];
    endcase
    if (job_r.err) begin
      item_byte = 8'd0;
    end else if (job_r.enc) begin
      item_byte = idx_to_char(sextet);
    end else begin
      item_byte = octet;
    end
  end

  // A new job is loaded as soon as the current one hands off its final result.
  always_comb begin
    q_pop         = !q_empty && (!job_valid_r || (fire && done));
    job_valid_nxt = job_valid_r;
    k_nxt         = k_r;
    if (fire) begin
      k_nxt = k_r + 2'd1;
      if (done) begin
        job_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      job_valid_nxt = 1'b1;
      k_nxt         = 2'd0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (fire) begin
      out_byte_r  <= item_byte;
      out_error_r <= job_r.err;
      out_last_r  <= job_r.last && done;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_error = out_error_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/base64url_codec.sv
// Streaming base64url codec without padding. Bit 0 of the register at address 0
// selects encode (0) or decode (1); any write to it discards a partly collected
// group and any pending error state. Items are accepted one per cycle while the
// internal job queue has room: the front end collects a group and queues one job
// per finished group, and the back end emits one result per cycle, when its
// output register is free or popped, from the oldest job into that register.
// Encoding thus sustains four characters per three bytes, set by the single
// result port; decoding sustains one character per cycle while results are popped.
// A group passes the job queue, job register and output register. A bad character
// yields one error result; the rest of its message is dropped up to its last item.
module base64url_codec #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_error,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import b64u_pkg::*;

  logic cfg_we, accept, direction;
  logic job_valid, q_full, q_empty, q_pop;
  job_t job, q_job;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, direction} : 32'd0;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  b64u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_dir   (cfg_pwdata[0]),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .direction (direction),
    .job_valid (job_valid),
    .job       (job)
  );

  b64u_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept && job_valid),
    .wr_job (job),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (q_job)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_byte  (out_byte),
    .out_error (out_error),
    .out_last  (out_last)
  );

endmodule
